// File: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers, clocked on clk_i; one is disabled by reset rst_ni.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define MSCS_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("mscs assertion failed");

// Checked during reset as well.
`define MSCS_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk_i) (prop)) \
    else $error("mscs assertion failed");

`endif

// File: sv/mscs_pkg.sv
// ----------------------------------------------------------------------------
// mscs_pkg
// Types and constants of the multi-stage battery charge sequencer.
// ----------------------------------------------------------------------------
package mscs_pkg;

  localparam int unsigned DataW  = 16;
  localparam int unsigned CntW   = 8;
  localparam int unsigned MinW   = 12;
  localparam int unsigned PhaseW = 3;
  localparam int unsigned CfgIdxW = 3;

  localparam logic [CntW-1:0] StableTicks      = CntW'(200);
  localparam logic [CntW-1:0] CntMax           = '1;
  localparam logic [MinW-1:0] MinMax           = '1;
  localparam logic [MinW-1:0] BulkLimitMin     = MinW'(48 * 60);
  localparam logic [MinW-1:0] AbsorbLimitMin   = MinW'(8 * 60);
  localparam logic [MinW-1:0] EqualizeLimitMin = MinW'(30);

  typedef enum logic [PhaseW-1:0] {
    PH_START  = 3'd0,
    PH_CHECK  = 3'd1,
    PH_BULK   = 3'd2,
    PH_ABSORB = 3'd3,
    PH_EQUAL  = 3'd4,
    PH_MAINT  = 3'd5,
    PH_ERROR  = 3'd6
  } phase_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_MIN_BATTERY_VOLTAGE = 3'd0,
    CFG_BULK_VOLTAGE        = 3'd1,
    CFG_EQUALIZE_VOLTAGE    = 3'd2,
    CFG_FLOAT_VOLTAGE       = 3'd3,
    CFG_BULK_CURRENT        = 3'd4,
    CFG_LOW_CURRENT         = 3'd5,
    CFG_VOLTAGE_DROP_MARGIN = 3'd6,
    CFG_IDLE_CURRENT        = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic [DataW-1:0] min_battery_voltage;
    logic [DataW-1:0] bulk_voltage;
    logic [DataW-1:0] equalize_voltage;
    logic [DataW-1:0] float_voltage;
    logic [DataW-1:0] bulk_current;
    logic [DataW-1:0] low_current;
    logic [DataW-1:0] voltage_drop_margin;
    logic [DataW-1:0] idle_current;
  } cfg_t;

  typedef struct packed {
    phase_e           phase;
    logic [CntW-1:0]  stable_count;
    logic [MinW-1:0]  phase_minutes;
    logic [DataW-1:0] voltage_command;
    logic [DataW-1:0] current_command;
  } chg_state_t;

endpackage

// File: sv/multi_stage_battery_charge_sequencer.sv
// ----------------------------------------------------------------------------
// multi_stage_battery_charge_sequencer
// Lead-acid charge phase sequencer with voltage and current setpoints.
// ----------------------------------------------------------------------------
// One transaction per control tick in, one result transaction out. A tick is
// captured in an input register and evaluated by the combinational phase
// logic into the result register, so a result passes through the input
// register and then the result register, and a new transaction is taken every
// cycle while the result side does not stall; the phase state registers are
// updated in the same cycle that the result register is loaded. While a
// result waits, one more transaction is still taken into the input register.
`include "assert_macros.svh"

module multi_stage_battery_charge_sequencer import mscs_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CfgIdxW-1:0]   cfg_index_i,
  input  logic [DataW-1:0]     cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [DataW-1:0]     battery_voltage_i,
  input  logic [DataW-1:0]     battery_current_i,
  input  logic                 duty_at_minimum_i,
  input  logic                 minute_tick_i,
  input  logic                 restart_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [DataW-1:0]     voltage_setpoint_o,
  output logic [DataW-1:0]     current_setpoint_o,
  output logic [PhaseW-1:0]    charge_phase_o
);

  cfg_t             cfg_q;
  chg_state_t       state_q, state_d;

  logic             s1_valid_q;
  logic [DataW-1:0] s1_volt_q, s1_curr_q;
  logic             s1_duty_q, s1_minute_q, s1_restart_q;

  logic             out_valid_q;
  logic [DataW-1:0] out_volt_q, out_curr_q;
  logic [PhaseW-1:0] out_phase_q;

  logic             out_ready;
  logic             advance;
  logic             in_accept;
  logic             bulk_entry;

  assign out_ready  = !out_valid_q || !out_stall_i;
  assign advance    = s1_valid_q && out_ready;
  assign in_stall_o = s1_valid_q && !out_ready;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_battery_voltage <= DataW'(500);
      cfg_q.bulk_voltage        <= DataW'(1600);
      cfg_q.equalize_voltage    <= DataW'(1670);
      cfg_q.float_voltage       <= DataW'(1470);
      cfg_q.bulk_current        <= DataW'(600);
      cfg_q.low_current         <= DataW'(100);
      cfg_q.voltage_drop_margin <= DataW'(50);
      cfg_q.idle_current        <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_MIN_BATTERY_VOLTAGE: cfg_q.min_battery_voltage <= cfg_wdata_i;
        CFG_BULK_VOLTAGE:        cfg_q.bulk_voltage        <= cfg_wdata_i;
        CFG_EQUALIZE_VOLTAGE:    cfg_q.equalize_voltage    <= cfg_wdata_i;
        CFG_FLOAT_VOLTAGE:       cfg_q.float_voltage       <= cfg_wdata_i;
        CFG_BULK_CURRENT:        cfg_q.bulk_current        <= cfg_wdata_i;
        CFG_LOW_CURRENT:         cfg_q.low_current         <= cfg_wdata_i;
        CFG_VOLTAGE_DROP_MARGIN: cfg_q.voltage_drop_margin <= cfg_wdata_i;
        CFG_IDLE_CURRENT:        cfg_q.idle_current        <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_accept) begin
      s1_valid_q <= 1'b1;
    end else if (advance) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_volt_q    <= battery_voltage_i;
      s1_curr_q    <= battery_current_i;
      s1_duty_q    <= duty_at_minimum_i;
      s1_minute_q  <= minute_tick_i;
      s1_restart_q <= restart_i;
    end
  end

  mscs_step u_step (
    .state_i           (state_q),
    .cfg_i             (cfg_q),
    .battery_voltage_i (s1_volt_q),
    .battery_current_i (s1_curr_q),
    .duty_at_minimum_i (s1_duty_q),
    .minute_tick_i     (s1_minute_q),
    .restart_i         (s1_restart_q),
    .state_o           (state_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.phase           <= PH_CHECK;
      state_q.stable_count    <= '0;
      state_q.phase_minutes   <= '0;
      state_q.voltage_command <= '0;
      state_q.current_command <= '0;
      out_valid_q             <= 1'b0;
    end else begin
      if (advance) begin
        state_q <= state_d;
      end
      out_valid_q <= advance || (out_valid_q && out_stall_i);
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_volt_q  <= state_d.voltage_command;
      out_curr_q  <= state_d.current_command;
      out_phase_q <= state_d.phase;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign voltage_setpoint_o = out_volt_q;
  assign current_setpoint_o = out_curr_q;
  assign charge_phase_o     = out_phase_q;

  assign bulk_entry = advance && !s1_restart_q && (state_q.phase == PH_CHECK) &&
                      (state_d.phase == PH_BULK);

  `MSCS_ASSERT_ALWAYS(a_stall_needs_item, !in_stall_o || s1_valid_q)
  `MSCS_ASSERT(a_restart_to_start, (advance && s1_restart_q) |=> (out_phase_q == PH_START))
  `MSCS_ASSERT(a_bulk_entry_clears, bulk_entry |=> (state_q.stable_count == '0))
  `MSCS_ASSERT(a_bulk_entry_timer, bulk_entry |=> (state_q.phase_minutes == '0))
  `MSCS_ASSERT(a_result_from_item, $rose(out_valid_q) |-> $past(s1_valid_q))

endmodule

// File: sv/mscs_step.sv
// ----------------------------------------------------------------------------
// mscs_step
// Next-state logic of the charge sequencer for one control tick.
// ----------------------------------------------------------------------------
module mscs_step import mscs_pkg::*; (
  input  chg_state_t       state_i,
  input  cfg_t             cfg_i,
  input  logic [DataW-1:0] battery_voltage_i,
  input  logic [DataW-1:0] battery_current_i,
  input  logic             duty_at_minimum_i,
  input  logic             minute_tick_i,
  input  logic             restart_i,
  output chg_state_t       state_o
);

  logic             cond;
  logic [CntW-1:0]  cnt_next;
  logic             settled;
  logic [MinW-1:0]  min_next;
  logic [DataW-1:0] maint_thr;

  assign min_next = (minute_tick_i && (state_i.phase_minutes != MinMax)) ?
                    state_i.phase_minutes + MinW'(1) : state_i.phase_minutes;

  assign maint_thr = (cfg_i.float_voltage > cfg_i.voltage_drop_margin) ?
                     cfg_i.float_voltage - cfg_i.voltage_drop_margin : '0;

  always_comb begin
    case (state_i.phase)
      PH_START:  cond = 1'b1;
      PH_CHECK:  cond = battery_voltage_i >= cfg_i.min_battery_voltage;
      PH_BULK:   cond = battery_voltage_i >= cfg_i.float_voltage;
      PH_ABSORB: cond = battery_current_i <= cfg_i.low_current;
      PH_EQUAL:  cond = battery_voltage_i >= cfg_i.equalize_voltage;
      PH_MAINT:  cond = battery_voltage_i < maint_thr;
      default:   cond = 1'b0;
    endcase
  end

  assign cnt_next = !cond ? '0 :
                    (state_i.stable_count == CntMax) ? CntMax :
                    state_i.stable_count + CntW'(1);
  assign settled  = cnt_next > StableTicks;

  always_comb begin
    state_o = state_i;
    if (restart_i) begin
      state_o.phase = PH_START;
    end else begin
      state_o.phase_minutes = min_next;
      case (state_i.phase)
        PH_START: begin
          state_o.voltage_command = '0;
          state_o.current_command = cfg_i.idle_current;
          state_o.stable_count    = cnt_next;
          if (settled && duty_at_minimum_i) begin
            state_o.phase        = PH_CHECK;
            state_o.stable_count = '0;
          end
        end
        PH_CHECK: begin
          state_o.stable_count = cnt_next;
          if (settled) begin
            state_o.voltage_command = cfg_i.bulk_voltage;
            state_o.current_command = cfg_i.bulk_current;
            state_o.stable_count    = '0;
            state_o.phase_minutes   = '0;
            state_o.phase           = PH_BULK;
          end
        end
        PH_BULK: begin
          state_o.stable_count = cnt_next;
          if (settled) begin
            state_o.stable_count    = '0;
            state_o.voltage_command = cfg_i.bulk_voltage;
            state_o.phase_minutes   = '0;
            state_o.phase           = PH_ABSORB;
          end else if (min_next > BulkLimitMin) begin
            state_o.phase = PH_ERROR;
          end
        end
        PH_ABSORB: begin
          state_o.stable_count = cnt_next;
          if (settled) begin
            state_o.voltage_command = cfg_i.float_voltage;
            state_o.current_command = cfg_i.low_current;
            state_o.stable_count    = '0;
            state_o.phase_minutes   = '0;
            state_o.phase           = PH_MAINT;
          end else if (min_next > AbsorbLimitMin) begin
            state_o.voltage_command = cfg_i.equalize_voltage;
            state_o.current_command = cfg_i.low_current;
            state_o.stable_count    = '0;
            state_o.phase_minutes   = '0;
            state_o.phase           = PH_EQUAL;
          end
        end
        PH_EQUAL: begin
          state_o.stable_count = cnt_next;
          if (settled) begin
            state_o.voltage_command = cfg_i.float_voltage;
            state_o.stable_count    = '0;
            state_o.phase           = PH_MAINT;
          end
          // timeout wins over the settled transition
          if (min_next > EqualizeLimitMin) begin
            state_o.phase = PH_CHECK;
          end
        end
        PH_MAINT: begin
          state_o.stable_count = cnt_next;
          if (settled) begin
            state_o.stable_count = '0;
            state_o.phase        = PH_CHECK;
          end
        end
        default: begin
          state_o.voltage_command = '0;
          state_o.current_command = '0;
        end
      endcase
    end
  end

endmodule

// File: tb/sv/multi_stage_battery_charge_sequencer_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_stage_battery_charge_sequencer_test
// Drives control ticks through the charge sequencer under random valid and
// stall gaps. A behavioral copy of the phase logic predicts each setpoint
// transaction whose expected value the stimulus table does not give, and the
// results are checked in order. A short stimulus table opens the run. Scenario
// walks follow under several register settings: stable runs through the phases,
// broken runs, noise with restarts, and runs with dense minute ticks.
// ----------------------------------------------------------------------------
module multi_stage_battery_charge_sequencer_test;
  import mscs_pkg::*;

  localparam int STABLE_TICKS    = 200;
  localparam int BULK_LIMIT      = 48 * 60;
  localparam int ABSORB_LIMIT    = 8 * 60;
  localparam int EQUALIZE_LIMIT  = 30;
  localparam int MINUTES_MAX     = 4095;
  localparam int WATCHDOG_CYCLES = 2000;
  localparam int ITEM_COUNT      = 450;

  typedef struct packed {
    logic [DataW-1:0] volt;
    logic [DataW-1:0] curr;
    logic             duty;
    logic             minute;
    logic             restart;
  } charge_tick_t;

  typedef struct packed {
    logic [DataW-1:0] vset;
    logic [DataW-1:0] iset;
    phase_e           phase;
  } setpoint_t;

  typedef struct packed {
    charge_tick_t tick;
    logic         typed;
    setpoint_t    want;
  } tick_row_t;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [CfgIdxW-1:0] cfg_index_i;
  logic [DataW-1:0]   cfg_wdata_i;
  logic               in_valid_i;
  logic               in_stall_o;
  logic [DataW-1:0]   battery_voltage_i;
  logic [DataW-1:0]   battery_current_i;
  logic               duty_at_minimum_i;
  logic               minute_tick_i;
  logic               restart_i;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [DataW-1:0]   voltage_setpoint_o;
  logic [DataW-1:0]   current_setpoint_o;
  logic [PhaseW-1:0]  charge_phase_o;

  multi_stage_battery_charge_sequencer i_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_index_i        (cfg_index_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .battery_voltage_i  (battery_voltage_i),
    .battery_current_i  (battery_current_i),
    .duty_at_minimum_i  (duty_at_minimum_i),
    .minute_tick_i      (minute_tick_i),
    .restart_i          (restart_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .voltage_setpoint_o (voltage_setpoint_o),
    .current_setpoint_o (current_setpoint_o),
    .charge_phase_o     (charge_phase_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predicted sequencer state
  cfg_t             charger_cfg;
  phase_e           model_phase;
  logic [CntW-1:0]  settle_count;
  logic [MinW-1:0]  phase_minutes;
  logic [DataW-1:0] volt_cmd;
  logic [DataW-1:0] curr_cmd;

  setpoint_t expected_setpoints [$];
  int        mismatches = 0;
  bit        no_idle = 1'b0;
  int        stall_left = 0;
  int        items_sent = 0;
  int        item_limit = 0;

  tick_row_t opening_ticks [14] = '{
    '{'{16'h0000, 16'h0000, 1'b0, 1'b0, 1'b0}, 1'b1, '{16'h0, 16'h0, PH_CHECK}},
    '{'{16'hFFFF, 16'hFFFF, 1'b1, 1'b1, 1'b1}, 1'b1, '{16'h0, 16'h0, PH_START}},
    '{'{16'h0000, 16'h0000, 1'b1, 1'b1, 1'b0}, 1'b1, '{16'h0, 16'h0, PH_START}},
    '{'{16'd499,  16'h0000, 1'b0, 1'b0, 1'b1}, 1'b1, '{16'h0, 16'h0, PH_START}},
    '{'{16'hFFFF, 16'hFFFF, 1'b0, 1'b1, 1'b0}, 1'b0, '{16'h0, 16'h0, PH_START}},
    '{'{16'h5555, 16'hAAAA, 1'b1, 1'b0, 1'b0}, 1'b0, '{16'h0, 16'h0, PH_START}},
    '{'{16'hAAAA, 16'h5555, 1'b0, 1'b1, 1'b0}, 1'b0, '{16'h0, 16'h0, PH_START}},
    '{'{16'd500,  16'd100,  1'b1, 1'b1, 1'b1}, 1'b0, '{16'h0, 16'h0, PH_START}},
    '{'{16'd1470, 16'd101,  1'b0, 1'b0, 1'b0}, 1'b0, '{16'h0, 16'h0, PH_START}},
    '{'{16'd1669, 16'd99,   1'b1, 1'b1, 1'b0}, 1'b0, '{16'h0, 16'h0, PH_START}},
    '{'{16'd1670, 16'd600,  1'b0, 1'b1, 1'b0}, 1'b0, '{16'h0, 16'h0, PH_START}},
    '{'{16'h0001, 16'hFFFE, 1'b1, 1'b0, 1'b0}, 1'b0, '{16'h0, 16'h0, PH_START}},
    '{'{16'hFFFE, 16'h0001, 1'b0, 1'b1, 1'b1}, 1'b0, '{16'h0, 16'h0, PH_START}},
    '{'{16'h8000, 16'h7FFF, 1'b1, 1'b1, 1'b0}, 1'b0, '{16'h0, 16'h0, PH_START}}
  };

  function automatic logic [DataW-1:0] recharge_level();
    if (charger_cfg.float_voltage > charger_cfg.voltage_drop_margin) begin
      return charger_cfg.float_voltage - charger_cfg.voltage_drop_margin;
    end
    return '0;
  endfunction

  function automatic void track_condition(bit holds);
    if (!holds) begin
      settle_count = '0;
    end else if (settle_count != '1) begin
      settle_count++;
    end
  endfunction

  function automatic setpoint_t charge_step(charge_tick_t t);
    setpoint_t r;
    if (t.restart) begin
      model_phase = PH_START;
    end else begin
      if (t.minute && phase_minutes != MINUTES_MAX) phase_minutes++;
      case (model_phase)
        PH_START: begin
          volt_cmd = '0;
          curr_cmd = charger_cfg.idle_current;
          track_condition(1'b1);
          if (settle_count > STABLE_TICKS && t.duty) begin
            model_phase  = PH_CHECK;
            settle_count = '0;
          end
        end
        PH_CHECK: begin
          track_condition(t.volt >= charger_cfg.min_battery_voltage);
          if (settle_count > STABLE_TICKS) begin
            volt_cmd      = charger_cfg.bulk_voltage;
            curr_cmd      = charger_cfg.bulk_current;
            settle_count  = '0;
            phase_minutes = '0;
            model_phase   = PH_BULK;
          end
        end
        PH_BULK: begin
          track_condition(t.volt >= charger_cfg.float_voltage);
          if (settle_count > STABLE_TICKS) begin
            settle_count  = '0;
            volt_cmd      = charger_cfg.bulk_voltage;
            phase_minutes = '0;
            model_phase   = PH_ABSORB;
          end
          if (phase_minutes > BULK_LIMIT) model_phase = PH_ERROR;
        end
        PH_ABSORB: begin
          track_condition(t.curr <= charger_cfg.low_current);
          if (settle_count > STABLE_TICKS) begin
            volt_cmd      = charger_cfg.float_voltage;
            curr_cmd      = charger_cfg.low_current;
            settle_count  = '0;
            phase_minutes = '0;
            model_phase   = PH_MAINT;
          end
          if (phase_minutes > ABSORB_LIMIT) begin
            volt_cmd      = charger_cfg.equalize_voltage;
            curr_cmd      = charger_cfg.low_current;
            settle_count  = '0;
            phase_minutes = '0;
            model_phase   = PH_EQUAL;
          end
        end
        PH_EQUAL: begin
          track_condition(t.volt >= charger_cfg.equalize_voltage);
          if (settle_count > STABLE_TICKS) begin
            volt_cmd     = charger_cfg.float_voltage;
            settle_count = '0;
            model_phase  = PH_MAINT;
          end
          // timeout wins over a same-tick settle
          if (phase_minutes > EQUALIZE_LIMIT) model_phase = PH_CHECK;
        end
        PH_MAINT: begin
          track_condition(t.volt < recharge_level());
          if (settle_count > STABLE_TICKS) begin
            settle_count = '0;
            model_phase  = PH_CHECK;
          end
        end
        default: begin
          volt_cmd = '0;
          curr_cmd = '0;
        end
      endcase
    end
    r.vset  = volt_cmd;
    r.iset  = curr_cmd;
    r.phase = model_phase;
    return r;
  endfunction

  function automatic logic [DataW-1:0] pick_value(int lo, int hi);
    case ($urandom_range(5, 0))
      0:       return DataW'(lo);
      1:       return DataW'(hi);
      default: return DataW'($urandom_range(hi, lo));
    endcase
  endfunction

  // Value at or above th when upper, else below th; random if that side is empty.
  function automatic logic [DataW-1:0] split_pick(int th, bit upper);
    if ((upper && th > 65535) || (!upper && th == 0)) return DataW'($urandom);
    return upper ? pick_value(th, 65535) : pick_value(0, th - 1);
  endfunction

  // Tick whose phase condition holds or fails as asked, given the predicted phase.
  function automatic charge_tick_t next_tick(bit holds, int minute_pct);
    charge_tick_t t;
    t.volt    = DataW'($urandom);
    t.curr    = DataW'($urandom);
    t.duty    = 1'($urandom_range(1, 0));
    t.minute  = ($urandom_range(99, 0) < minute_pct);
    t.restart = 1'b0;
    case (model_phase)
      PH_START:  t.duty = holds ? ($urandom_range(39, 0) == 0) : 1'b0;
      PH_CHECK:  t.volt = split_pick(int'(charger_cfg.min_battery_voltage), holds);
      PH_BULK:   t.volt = split_pick(int'(charger_cfg.float_voltage), holds);
      PH_ABSORB: t.curr = split_pick(int'(charger_cfg.low_current) + 1, !holds);
      PH_EQUAL:  t.volt = split_pick(int'(charger_cfg.equalize_voltage), holds);
      PH_MAINT:  t.volt = split_pick(int'(recharge_level()), !holds);
      default: ;
    endcase
    return t;
  endfunction

  task automatic send_tick(charge_tick_t t, bit typed = 1'b0, setpoint_t want = '0);
    int        gap;
    setpoint_t predicted;
    gap = no_idle ? 0 : $urandom_range(5, 0);
    @(negedge clk_i);
    if (gap != 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    battery_voltage_i = t.volt;
    battery_current_i = t.curr;
    duty_at_minimum_i = t.duty;
    minute_tick_i     = t.minute;
    restart_i         = t.restart;
    in_valid_i        = 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    predicted = charge_step(t);
    expected_setpoints.push_back(typed ? want : predicted);
    items_sent++;
  endtask

  task automatic drain_results();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (expected_setpoints.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic program_registers(logic [DataW-1:0] setting [8]);
    cfg_idx_e idx;
    for (int i = 0; i < 8; i++) begin
      idx = cfg_idx_e'(i);
      @(negedge clk_i);
      cfg_we_i    = 1'b1;
      cfg_index_i = idx;
      cfg_wdata_i = setting[i];
      case (idx)
        CFG_MIN_BATTERY_VOLTAGE: charger_cfg.min_battery_voltage = setting[i];
        CFG_BULK_VOLTAGE:        charger_cfg.bulk_voltage        = setting[i];
        CFG_EQUALIZE_VOLTAGE:    charger_cfg.equalize_voltage    = setting[i];
        CFG_FLOAT_VOLTAGE:       charger_cfg.float_voltage       = setting[i];
        CFG_BULK_CURRENT:        charger_cfg.bulk_current        = setting[i];
        CFG_LOW_CURRENT:         charger_cfg.low_current         = setting[i];
        CFG_VOLTAGE_DROP_MARGIN: charger_cfg.voltage_drop_margin = setting[i];
        CFG_IDLE_CURRENT:        charger_cfg.idle_current        = setting[i];
        default: ;
      endcase
    end
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic run_until_change(bit holds, int minute_pct, int cap);
    phase_e start_phase;
    int     n;
    start_phase = model_phase;
    n = 0;
    while (model_phase == start_phase && n < cap && items_sent < item_limit) begin
      send_tick(next_tick(holds, minute_pct));
      n++;
    end
  endtask

  task automatic run_walk();
    int           kind;
    int           minute_pct;
    int           n;
    charge_tick_t t;
    if (items_sent >= item_limit) return;
    no_idle    = ($urandom_range(3, 0) == 0);
    minute_pct = $urandom_range(30, 0);
    kind       = $urandom_range(19, 0);
    if (kind <= 10) begin
      if (model_phase == PH_ERROR) begin
        t = next_tick(1'b1, minute_pct);
        t.restart = 1'b1;
        send_tick(t);
      end else begin
        run_until_change(1'b1, minute_pct, 300);
      end
    end else if (kind <= 14) begin
      run_until_change(1'b1, minute_pct, $urandom_range(215, 1));
      if (items_sent < item_limit) send_tick(next_tick(1'b0, minute_pct));
    end else if (kind <= 17) begin
      n = $urandom_range(20, 3);
      while (n > 0 && items_sent < item_limit) begin
        t = next_tick(1'($urandom_range(1, 0)), 50);
        t.volt    = DataW'($urandom);
        t.curr    = DataW'($urandom);
        t.restart = ($urandom_range(5, 0) == 0);
        send_tick(t);
        n--;
      end
    end else begin
      case (model_phase)
        PH_ABSORB: run_until_change(1'b0, 100, 500);
        PH_EQUAL:  run_until_change(1'b0, 100, 40);
        PH_BULK:   run_until_change(1'b0, 100, 60);
        default:   run_until_change(1'b0, 100, 30);
      endcase
    end
    if ($urandom_range(7, 0) == 0) drain_results();
  endtask

  // Result side: stall draw per transaction, applied on the falling edge
  always @(negedge clk_i) begin
    out_stall_i <= (stall_left != 0);
    if (stall_left != 0) stall_left--;
  end

  always @(posedge clk_i) begin
    setpoint_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_setpoints.size() == 0) begin
        $display("%0t: unexpected result %0d %0d %0d", $time, voltage_setpoint_o,
                 current_setpoint_o, charge_phase_o);
        mismatches++;
      end else begin
        want = expected_setpoints.pop_front();
        if (voltage_setpoint_o !== want.vset) begin
          $display("%0t: voltage_setpoint expected %0d got %0d", $time, want.vset,
                   voltage_setpoint_o);
          mismatches++;
        end
        if (current_setpoint_o !== want.iset) begin
          $display("%0t: current_setpoint expected %0d got %0d", $time, want.iset,
                   current_setpoint_o);
          mismatches++;
        end
        if (charge_phase_o !== want.phase) begin
          $display("%0t: charge_phase expected %0d got %0d", $time, want.phase,
                   charge_phase_o);
          mismatches++;
        end
      end
      stall_left = no_idle ? 0 : $urandom_range(5, 0);
    end
  end

  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_CYCLES) begin
      @(posedge clk_i);
      if (!rst_ni || cfg_we_i || (in_valid_i && !in_stall_o) ||
          (out_valid_o && !out_stall_i)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("Mismatches found");
    $finish;
  end

  initial begin
    logic [DataW-1:0] setting [8];
    rst_ni            = 1'b0;
    cfg_we_i          = 1'b0;
    cfg_index_i       = '0;
    cfg_wdata_i       = '0;
    in_valid_i        = 1'b0;
    battery_voltage_i = '0;
    battery_current_i = '0;
    duty_at_minimum_i = 1'b0;
    minute_tick_i     = 1'b0;
    restart_i         = 1'b0;

    charger_cfg.min_battery_voltage = 16'd500;
    charger_cfg.bulk_voltage        = 16'd1600;
    charger_cfg.equalize_voltage    = 16'd1670;
    charger_cfg.float_voltage       = 16'd1470;
    charger_cfg.bulk_current        = 16'd600;
    charger_cfg.low_current         = 16'd100;
    charger_cfg.voltage_drop_margin = 16'd50;
    charger_cfg.idle_current        = 16'd0;
    model_phase   = PH_CHECK;
    settle_count  = '0;
    phase_minutes = '0;
    volt_cmd      = '0;
    curr_cmd      = '0;

    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (opening_ticks[i]) begin
      send_tick(opening_ticks[i].tick, opening_ticks[i].typed, opening_ticks[i].want);
    end

    for (int step = 0; step < 6; step++) begin
      drain_results();
      foreach (setting[i]) setting[i] = DataW'($urandom);
      case (step)
        0: begin
          setting[CFG_MIN_BATTERY_VOLTAGE] = DataW'($urandom_range(1400, 0));
          setting[CFG_BULK_VOLTAGE]        = DataW'($urandom_range(1700, 1400));
          setting[CFG_EQUALIZE_VOLTAGE]    = DataW'($urandom_range(1800, 1500));
          setting[CFG_FLOAT_VOLTAGE]       = DataW'($urandom_range(1500, 1000));
          setting[CFG_LOW_CURRENT]         = DataW'($urandom_range(600, 20));
          setting[CFG_VOLTAGE_DROP_MARGIN] = DataW'($urandom_range(100, 0));
        end
        1: foreach (setting[i]) setting[i] = '0;
        2: foreach (setting[i]) setting[i] = '1;
        3: begin
          // recharge threshold clamps at zero
          setting[CFG_FLOAT_VOLTAGE]       = DataW'($urandom_range(200, 0));
          setting[CFG_VOLTAGE_DROP_MARGIN] = DataW'($urandom_range(65535,
                                                    setting[CFG_FLOAT_VOLTAGE]));
        end
        4: ;
        default: begin
          setting[CFG_MIN_BATTERY_VOLTAGE] = 16'd500;
          setting[CFG_BULK_VOLTAGE]        = 16'd1600;
          setting[CFG_EQUALIZE_VOLTAGE]    = 16'd1670;
          setting[CFG_FLOAT_VOLTAGE]       = 16'd1470;
          setting[CFG_BULK_CURRENT]        = 16'd600;
          setting[CFG_LOW_CURRENT]         = 16'd100;
          setting[CFG_VOLTAGE_DROP_MARGIN] = 16'd50;
          setting[CFG_IDLE_CURRENT]        = 16'd0;
        end
      endcase
      program_registers(setting);
      item_limit = $size(opening_ticks) +
                   ((ITEM_COUNT - $size(opening_ticks)) * (step + 1)) / 6;
      while (items_sent < item_limit) run_walk();
    end

    drain_results();
    repeat (4) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
